/* rtl/core/spq_pkg.sv */
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int VALUE_W      = 32;
  localparam int PRIO_W       = 16;
  localparam int OCC_W        = 5;
  localparam int STATUS_W     = 2;
  localparam int DEF_CAPACITY = 16;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  // Per-cell control, driven by the queue controller.
  typedef struct packed {
    logic ins;       // an insert is being applied this cycle
    logic del;       // a delete is being applied this cycle
    logic occupied;  // this cell holds a live entry
    logic tail;      // this cell is the first free slot
  } spq_ctl_t;

endpackage

/* rtl/core/spq_cell.sv */
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds a priority and value, and takes its
// left or right neighbor's entry, or the new entry, as the operation demands.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
(
  input  logic               clk,
  input  spq_ctl_t           ctl,
  input  logic [PRIO_W-1:0]  new_prio,
  input  logic [VALUE_W-1:0] new_value,
  input  logic               left_shift,
  input  logic [PRIO_W-1:0]  left_prio,
  input  logic [VALUE_W-1:0] left_value,
  input  logic [PRIO_W-1:0]  right_prio,
  input  logic [VALUE_W-1:0] right_value,
  output logic               shift,
  output logic [PRIO_W-1:0]  prio,
  output logic [VALUE_W-1:0] value
);

  logic take;

  // A strictly lower new priority pushes this entry right, so equal
  // priorities stay in arrival order.
  assign shift = ctl.ins && ctl.occupied && (new_prio < prio);
  assign take  = shift || (ctl.ins && ctl.tail);

  always_ff @(posedge clk) begin
    if (ctl.del) begin
      prio  <= right_prio;
      value <= right_value;
    end else if (take) begin
      if (left_shift) begin
        prio  <= left_prio;
        value <= left_value;
      end else begin
        prio  <= new_prio;
        value <= new_value;
      end
    end
  end

endmodule

/* rtl/core/sorted_priority_queue.sv */
// Latency: a result appears in the cycle after its input transfer.
// Throughput: one insert or delete per cycle while the input is not stalled; all cells update in parallel.
// The input stalls only while a result is held by a stalled output.
// Reset clears the entry count and the output valid; the cells keep their
// contents, which are never read before being written.
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded min-first priority queue built as a chain of sorted cells.
// ----------------------------------------------------------------------------
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       opcode,
  input  logic signed [VALUE_W-1:0]  value_in,
  input  logic        [PRIO_W-1:0]   prio_in,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic        [STATUS_W-1:0] status,
  output logic signed [VALUE_W-1:0]  value_out,
  output logic        [OCC_W-1:0]    occupancy
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic               accept;
  logic               full;
  logic               empty;
  logic               do_ins;
  logic               do_del;

  logic [PRIO_W-1:0]  cell_prio  [CAPACITY];
  logic [VALUE_W-1:0] cell_value [CAPACITY];
  logic               cell_shift [CAPACITY];

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = (count == CNT_W'(CAPACITY));
  assign empty    = (count == '0);
  assign do_ins   = accept && (opcode == OP_INSERT) && !full;
  assign do_del   = accept && (opcode == OP_DELETE) && !empty;

  always_comb begin
    count_next = count;
    if (do_ins) begin
      count_next = count + CNT_W'(1);
    end else if (do_del) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    spq_ctl_t           ctl;
    logic               l_shift;
    logic [PRIO_W-1:0]  l_prio;
    logic [VALUE_W-1:0] l_value;
    logic [PRIO_W-1:0]  r_prio;
    logic [VALUE_W-1:0] r_value;

    assign ctl.ins      = do_ins;
    assign ctl.del      = do_del;
    assign ctl.occupied = (CNT_W'(i) < count);
    assign ctl.tail     = (CNT_W'(i) == count);

    if (i == 0) begin : g_head
      assign l_shift = 1'b0;
      assign l_prio  = prio_in;
      assign l_value = value_in;
    end else begin : g_body
      assign l_shift = cell_shift[i-1];
      assign l_prio  = cell_prio[i-1];
      assign l_value = cell_value[i-1];
    end

    // The last cell has no right neighbor; what it takes on a delete is
    // beyond the count and never read.
    if (i == CAPACITY - 1) begin : g_last
      assign r_prio  = cell_prio[i];
      assign r_value = cell_value[i];
    end else begin : g_inner
      assign r_prio  = cell_prio[i+1];
      assign r_value = cell_value[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .new_prio    (prio_in),
      .new_value   (value_in),
      .left_shift  (l_shift),
      .left_prio   (l_prio),
      .left_value  (l_value),
      .right_prio  (r_prio),
      .right_value (r_value),
      .shift       (cell_shift[i]),
      .prio        (cell_prio[i]),
      .value       (cell_value[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      occupancy <= OCC_W'(count_next);
      value_out <= do_del ? cell_value[0] : '0;
      if (opcode == OP_INSERT) begin
        status <= full ? STATUS_FULL : STATUS_OK;
      end else begin
        status <= empty ? STATUS_EMPTY : STATUS_OK;
      end
    end
  end

endmodule

/* bench/spq_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_checker
// Watches both channels of the sorted priority queue, keeps a mirror of the
// queue contents, and compares every output transfer with the oldest
// predicted result. Mismatch and outstanding counts go back to the bench top.
// ----------------------------------------------------------------------------
module spq_checker
  import spq_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic                       opcode,
  input  logic signed [VALUE_W-1:0]  value_in,
  input  logic        [PRIO_W-1:0]   prio_in,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic        [STATUS_W-1:0] status,
  input  logic signed [VALUE_W-1:0]  value_out,
  input  logic        [OCC_W-1:0]    occupancy,
  output int                         mismatches,
  output int                         outstanding
);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  value;
    logic [OCC_W-1:0]    occ;
  } spq_result_t;

  logic [VALUE_W-1:0] mirror_values [CAPACITY];
  logic [PRIO_W-1:0]  mirror_prios  [CAPACITY];
  int                 mirror_fill;
  spq_result_t        due_results [$];

  // Applies one operation to the mirror and returns the result it must give.
  function automatic spq_result_t predict_queue_op(input logic op,
                                                   input logic [VALUE_W-1:0] val,
                                                   input logic [PRIO_W-1:0] pri);
    spq_result_t res;
    int          pos;
    res.status = STATUS_OK;
    res.value  = '0;
    if (op == OP_INSERT) begin
      if (mirror_fill >= CAPACITY) begin
        res.status = STATUS_FULL;
      end else begin
        // A new entry goes behind every entry of the same priority.
        pos = 0;
        while (pos < mirror_fill && mirror_prios[pos] <= pri) pos++;
        for (int i = mirror_fill; i > pos; i--) begin
          mirror_values[i] = mirror_values[i-1];
          mirror_prios[i]  = mirror_prios[i-1];
        end
        mirror_values[pos] = val;
        mirror_prios[pos]  = pri;
        mirror_fill++;
      end
    end else begin
      if (mirror_fill == 0) begin
        res.status = STATUS_EMPTY;
      end else begin
        res.value = mirror_values[0];
        for (int i = 1; i < mirror_fill; i++) begin
          mirror_values[i-1] = mirror_values[i];
          mirror_prios[i-1]  = mirror_prios[i];
        end
        mirror_fill--;
      end
    end
    res.occ = OCC_W'(mirror_fill);
    return res;
  endfunction

  task automatic log_mismatch(input string what, input string want_s, input string got_s);
    $display("%0t: %s mismatch, expected %s, got %s", $time, what, want_s, got_s);
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    spq_result_t want;
    if (rst) begin
      mirror_fill = 0;
      due_results.delete();
    end else begin
      if (in_valid && !in_stall)
        due_results.push_back(predict_queue_op(opcode, value_in, prio_in));
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          log_mismatch("unexpected result", "none",
                       $sformatf("status %0d value %0d occupancy %0d",
                                 status, value_out, occupancy));
        end else begin
          want = due_results.pop_front();
          if (status !== want.status)
            log_mismatch("status", $sformatf("%0d", want.status), $sformatf("%0d", status));
          if (value_out !== $signed(want.value))
            log_mismatch("value_out", $sformatf("%0d", $signed(want.value)),
                         $sformatf("%0d", value_out));
          if (occupancy !== want.occ)
            log_mismatch("occupancy", $sformatf("%0d", want.occ),
                         $sformatf("%0d", occupancy));
        end
      end
    end
    // Published with a nonblocking update so the top reads a settled count.
    outstanding <= due_results.size();
  end

endmodule

/* bench/tb_sorted_priority_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue
// Drives inserts and deletes into the sorted priority queue with bursty
// input timing and a patterned output stall. A directed opening covers the
// empty, full, extreme and equal-priority cases; a long random part follows
// with a shifting insert/delete mix so the queue swings between empty and full.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue;
  import spq_pkg::*;

  localparam int DEPTH      = DEF_CAPACITY;
  localparam int RANDOM_OPS = 1425;

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      in_valid  = 1'b0;
  logic                      opcode    = OP_INSERT;
  logic signed [VALUE_W-1:0] value_in  = '0;
  logic        [PRIO_W-1:0]  prio_in   = '0;
  logic                      out_stall = 1'b0;

  logic                      in_stall;
  logic                      out_valid;
  logic        [STATUS_W-1:0] status;
  logic signed [VALUE_W-1:0]  value_out;
  logic        [OCC_W-1:0]    occupancy;

  int mismatches;
  int outstanding;
  int burst_left = 0;

  int stall_mode      = 0;
  int stall_mode_left = 0;
  int stall_phase     = 0;

  sorted_priority_queue #(.CAPACITY(DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .value_in  (value_in),
    .prio_in   (prio_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .value_out (value_out),
    .occupancy (occupancy)
  );

  spq_checker #(.CAPACITY(DEPTH)) u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .value_in    (value_in),
    .prio_in     (prio_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .value_out   (value_out),
    .occupancy   (occupancy),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // The receiver switches among free flow, light and heavy random stalls,
  // and a periodic stall pattern.
  always @(posedge clk) begin
    if (rst) begin
      out_stall       <= 1'b0;
      stall_mode_left <= 0;
    end else begin
      stall_phase <= (stall_phase + 1) % 11;
      if (stall_mode_left == 0) begin
        stall_mode      <= $urandom_range(0, 3);
        stall_mode_left <= $urandom_range(20, 200);
      end else begin
        stall_mode_left <= stall_mode_left - 1;
      end
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 9) < 7);
        default: out_stall <= (stall_phase < 4);
      endcase
    end
  end

  // Holds one transfer on the input until the block takes it.
  task automatic send_op(input logic op, input logic [VALUE_W-1:0] val,
                         input logic [PRIO_W-1:0] pri);
    in_valid <= 1'b1;
    opcode   <= op;
    value_in <= val;
    prio_in  <= pri;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Ends a burst with an idle gap; some bursts follow with no gap at all.
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin
    int                 insert_pct;
    int                 guard;
    logic [VALUE_W-1:0] val;
    logic [PRIO_W-1:0]  pri;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed opening: empty delete, extremes, ties, a full queue.
    send_op(OP_DELETE, 32'h1234_5678, 16'hBEEF);
    send_op(OP_INSERT, 32'h7FFF_FFFF, 16'hFFFF);
    send_op(OP_INSERT, 32'h8000_0000, 16'h0000);
    send_op(OP_INSERT, 32'h0000_0000, 16'd100);
    send_op(OP_INSERT, 32'hFFFF_FFFF, 16'd100);
    send_op(OP_INSERT, 32'h0000_0001, 16'd100);
    send_op(OP_INSERT, 32'h0000_0005, 16'h0000);
    send_op(OP_INSERT, 32'h0000_0006, 16'hFFFF);
    for (int i = 7; i < DEPTH; i++) send_op(OP_INSERT, $urandom, 16'(40 + 3 * i));
    send_op(OP_INSERT, 32'h5555_5555, 16'h0000);
    for (int i = 0; i < 4; i++) send_op(OP_DELETE, $urandom, 16'($urandom));
    wait_drained();

    insert_pct = 50;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(0, 3))
          0:       insert_pct = 15;
          1:       insert_pct = 50;
          2:       insert_pct = 85;
          default: insert_pct = 95;
        endcase
      end
      if (n % 400 == 399) wait_drained();
      pace_sender();
      case ($urandom_range(0, 9))
        0:       val = 32'h8000_0000;
        1:       val = 32'h7FFF_FFFF;
        default: val = $urandom;
      endcase
      // Narrow priorities make ties common.
      case ($urandom_range(0, 9))
        0:       pri = '0;
        1:       pri = '1;
        2, 3, 4: pri = 16'($urandom_range(0, 7));
        default: pri = 16'($urandom);
      endcase
      send_op(($urandom_range(1, 100) <= insert_pct) ? OP_INSERT : OP_DELETE, val, pri);
    end

    in_valid <= 1'b0;
    guard = 0;
    do begin
      @(posedge clk);
      guard++;
    end while (outstanding != 0 && guard < 2000);
    repeat (4) @(posedge clk);
    @(negedge clk);
    if (outstanding != 0)
      $display("%0t: %0d expected results never arrived", $time, outstanding);
    if (mismatches == 0 && outstanding == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("%0t: run did not finish in time", $time);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
